// ----- rtl/mvob_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package mvob_pkg;

  typedef enum logic [1:0] {
    OP_ADD     = 2'd0,
    OP_CANCEL  = 2'd1,
    OP_REPLACE = 2'd2,
    OP_EXECUTE = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    LA_NEW  = 3'd0,
    LA_REC  = 3'd1,
    LA_PREV = 3'd2,
    LA_SRCH = 3'd3,
    LA_CLR  = 3'd4
  } la_sel_t;

  typedef enum logic {
    OA_NEW = 1'b0,
    OA_OLD = 1'b1
  } oa_sel_t;

  localparam logic KIND_BEST = 1'b0;
  localparam logic KIND_LINE = 1'b1;

  typedef struct packed {
    logic    load;
    logic    clr;
    la_sel_t la_sel;
    oa_sel_t oa_sel;
    logic    oa_lat;
    logic    add_wr;
    logic    rpt_out;
    logic    ord_upd;
    logic    rem_wr;
    logic    srch_init;
    logic    srch_chk;
    logic    line_init;
    logic    line_emit;
  } ctrl_cmd_t;

  typedef struct packed {
    op_t  op;
    logic add_ok;
    logic oid_ok;
    logic old_ok;
    logic clr_done;
    logic rpt_need;
    logic rec_valid;
    logic emptied_hit;
    logic srch_stop;
    logic line_last;
  } dp_stat_t;

  function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  function automatic logic [31:0] sat_sub(input logic [31:0] a, input logic [31:0] b);
    return (b > a) ? 32'd0 : a - b;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/mvob_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none
module mvob_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  output logic                      busy,
  input  mvob_pkg::dp_stat_t        st,
  output mvob_pkg::ctrl_cmd_t       cmd
);
  import mvob_pkg::*;

  typedef enum logic [15:0] {
    ST_CLR      = 16'h0001,
    ST_IDLE     = 16'h0002,
    ST_DISP     = 16'h0004,
    ST_ADD_RD   = 16'h0008,
    ST_ADD_WR   = 16'h0010,
    ST_RPT_RD   = 16'h0020,
    ST_RPT_OUT  = 16'h0040,
    ST_ORD_RD   = 16'h0080,
    ST_OLD_RD   = 16'h0100,
    ST_ORD_CHK  = 16'h0200,
    ST_REM_RD   = 16'h0400,
    ST_REM_WR   = 16'h0800,
    ST_SRCH_RD  = 16'h1000,
    ST_SRCH_CHK = 16'h2000,
    ST_LINE_RD  = 16'h4000,
    ST_LINE     = 16'h8000
  } state_t;

  state_t state_r, state_nxt;
  state_t after_add, after_rem;

  assign busy = (state_r != ST_IDLE);

  always_comb begin
    after_add = (st.op == OP_REPLACE && st.old_ok) ? ST_OLD_RD : ST_IDLE;
    after_rem = (st.op == OP_EXECUTE) ? ST_LINE_RD : ST_IDLE;
  end

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    cmd.la_sel = LA_NEW;
    cmd.oa_sel = OA_NEW;
    unique case (state_r)
      ST_CLR: begin
        cmd.clr = 1'b1;
        cmd.la_sel = LA_CLR;
        if (st.clr_done) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          state_nxt = ST_DISP;
        end
      end
      ST_DISP: begin
        unique case (st.op)
          OP_ADD:     state_nxt = st.add_ok ? ST_ADD_RD : ST_IDLE;
          OP_REPLACE: state_nxt = st.add_ok ? ST_ADD_RD : after_add;
          OP_CANCEL,
          OP_EXECUTE: state_nxt = st.oid_ok ? ST_ORD_RD : ST_IDLE;
          default:    state_nxt = ST_IDLE;
        endcase
      end
      ST_ADD_RD: state_nxt = ST_ADD_WR;
      ST_ADD_WR: begin
        cmd.add_wr = 1'b1;
        state_nxt = st.rpt_need ? ST_RPT_RD : after_add;
      end
      ST_RPT_RD: begin
        cmd.la_sel = LA_PREV;
        state_nxt = ST_RPT_OUT;
      end
      ST_RPT_OUT: begin
        cmd.la_sel = LA_PREV;
        cmd.rpt_out = 1'b1;
        state_nxt = after_add;
      end
      ST_ORD_RD: begin
        cmd.oa_lat = 1'b1;
        state_nxt = ST_ORD_CHK;
      end
      ST_OLD_RD: begin
        cmd.oa_sel = OA_OLD;
        cmd.oa_lat = 1'b1;
        state_nxt = ST_ORD_CHK;
      end
      ST_ORD_CHK: begin
        cmd.ord_upd = st.rec_valid;
        state_nxt = st.rec_valid ? ST_REM_RD : ST_IDLE;
      end
      ST_REM_RD: begin
        cmd.la_sel = LA_REC;
        state_nxt = ST_REM_WR;
      end
      ST_REM_WR: begin
        cmd.la_sel = LA_REC;
        cmd.rem_wr = 1'b1;
        cmd.srch_init = st.emptied_hit;
        state_nxt = st.emptied_hit ? ST_SRCH_RD : after_rem;
      end
      ST_SRCH_RD: begin
        cmd.la_sel = LA_SRCH;
        state_nxt = ST_SRCH_CHK;
      end
      ST_SRCH_CHK: begin
        cmd.la_sel = LA_SRCH;
        cmd.srch_chk = 1'b1;
        state_nxt = st.srch_stop ? after_rem : ST_SRCH_RD;
      end
      ST_LINE_RD: begin
        cmd.la_sel = LA_REC;
        cmd.line_init = 1'b1;
        state_nxt = ST_LINE;
      end
      ST_LINE: begin
        cmd.la_sel = LA_REC;
        cmd.line_emit = 1'b1;
        if (st.line_last) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_CLR;
    else        state_r <= state_nxt;
  end

  a_onehot: assert property (@(posedge clk) disable iff (!rst_n) $onehot(state_r))
    else $error("state not one-hot");
  a_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (start && state_r == ST_IDLE) |=> state_r == ST_DISP)
    else $error("accepted item not dispatched");
  a_lines: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_LINE && st.line_last) |=> state_r == ST_IDLE)
    else $error("line burst did not end");

endmodule
`default_nettype wire

// ----- rtl/mvob_dp.sv -----
`timescale 1ns / 1ps
`default_nettype none
module mvob_dp #(
  parameter int ORDER_SLOTS  = 1024,
  parameter int PRICE_LEVELS = 4096,
  parameter int VENUE_COUNT  = 14
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  mvob_pkg::ctrl_cmd_t  cmd,
  output mvob_pkg::dp_stat_t   st,
  input  wire logic [1:0]      in_opcode,
  input  wire logic [9:0]      in_order_id,
  input  wire logic [9:0]      in_old_order_id,
  input  wire logic [3:0]      in_venue,
  input  wire logic            in_side,
  input  wire logic [11:0]     in_price_ticks,
  input  wire logic [31:0]     in_quantity,
  output logic                 out_valid,
  output logic                 out_report_kind,
  output logic [11:0]          out_price_out,
  output logic [31:0]          out_level_total,
  output logic [11:0]          out_old_price,
  output logic [31:0]          out_old_level_total,
  output logic [13:0]          out_venue_mask,
  output logic [3:0]           out_line_venue,
  output logic [31:0]          out_line_venue_qty,
  output logic                 out_last
);
  import mvob_pkg::*;

  localparam int LD   = 2 * PRICE_LEVELS;
  localparam int LAW  = $clog2(LD);
  localparam int OW   = $clog2(ORDER_SLOTS);
  localparam int PIW  = $clog2(PRICE_LEVELS);
  localparam int PW   = $clog2(PRICE_LEVELS + 1);
  localparam int VW   = (VENUE_COUNT > 1) ? $clog2(VENUE_COUNT) : 1;
  localparam int RW   = 33 + 32 * VENUE_COUNT;
  localparam int O_PR = 2;
  localparam int O_VN = 2 + PIW;
  localparam int O_QT = 2 + PIW + VW;
  localparam int ORW  = O_QT + 32;
  localparam int CD   = (LD > ORDER_SLOTS) ? LD : ORDER_SLOTS;
  localparam int CW   = $clog2(CD);
  localparam logic [PW-1:0] EMPTY = PW'(PRICE_LEVELS);

  function automatic logic [LAW-1:0] lvl(input logic s, input logic [PIW-1:0] p);
    return s ? LAW'(PRICE_LEVELS) + LAW'(p) : LAW'(p);
  endfunction

  function automatic logic [15:0] row_mask(input logic [RW-1:0] row);
    logic [15:0] m;
    m = '0;
    for (int v = 0; v < VENUE_COUNT; v++) m[v] = (row[33 + 32 * v +: 32] != 32'd0);
    return m;
  endfunction

  // latched item
  op_t         op_r;
  logic [9:0]  oid_r, old_r;
  logic [3:0]  ven_r;
  logic        side_r;
  logic [11:0] price_r;
  logic [31:0] qty_r;
  logic [PIW-1:0] price_i;
  logic [VW-1:0]  ven_i;

  // order record under work
  logic           rec_side_r;
  logic [PIW-1:0] rec_price_r;
  logic [VW-1:0]  rec_ven_r;
  logic [31:0]    rq_r;
  logic [OW-1:0]  oaddr_r;

  logic [PW-1:0]  best_r [2];
  logic [PW-1:0]  prev_r;
  logic [31:0]    nsum_r;
  logic           ss_r;
  logic [PIW-1:0] sp_r;
  logic [VW-1:0]  lv_r;
  logic [CW-1:0]  clr_r;

  // memories
  logic [RW-1:0]  lmem [LD];
  logic [ORW-1:0] omem [ORDER_SLOTS];
  logic [RW-1:0]  lrd_q;
  logic [ORW-1:0] ord_q;
  logic [LAW-1:0] la;
  logic           lwe;
  logic [RW-1:0]  lwd;
  logic [OW-1:0]  oa_rd, oa_wr;
  logic           owe;
  logic [ORW-1:0] owd;

  logic [VW-1:0]  vsel;
  logic [31:0]    vq_old, sum_old, vq_new, sum_new;
  logic [RW-1:0]  row_upd;
  logic [PW-1:0]  prev_cur;
  logic           better;
  logic [31:0]    take, newq;
  logic           srch_end;
  logic [15:0]    mask;

  assign price_i = PIW'(price_r);
  assign ven_i   = VW'(ven_r);

  always_comb begin
    unique case (cmd.la_sel)
      LA_NEW:  la = lvl(side_r, price_i);
      LA_REC:  la = lvl(rec_side_r, rec_price_r);
      LA_PREV: la = lvl(side_r, PIW'(prev_r));
      LA_SRCH: la = lvl(ss_r, sp_r);
      LA_CLR:  la = LAW'(clr_r);
      default: la = LAW'(clr_r);
    endcase
    oa_rd = (cmd.oa_sel == OA_OLD) ? OW'(old_r) : OW'(oid_r);
  end

  // level row update, shared by add and remove
  always_comb begin
    vsel    = cmd.add_wr ? ven_i : rec_ven_r;
    vq_old  = lrd_q[33 + 32 * vsel +: 32];
    sum_old = lrd_q[32:1];
    if (cmd.add_wr) begin
      vq_new  = sat_add(vq_old, qty_r);
      sum_new = sat_add(sum_old, qty_r);
    end else begin
      vq_new  = sat_sub(vq_old, rq_r);
      sum_new = sat_sub(sum_old, rq_r);
    end
    row_upd = lrd_q;
    row_upd[33 + 32 * vsel +: 32] = vq_new;
    row_upd[32:1] = sum_new;
    if (cmd.add_wr) row_upd[0] = 1'b1;
    else if (sum_new == 32'd0) row_upd = '0;
  end

  always_comb begin
    lwe = (cmd.clr && (32'(clr_r) < LD)) || cmd.add_wr || cmd.rem_wr;
    lwd = cmd.clr ? '0 : row_upd;
  end

  always_ff @(posedge clk) begin
    if (lwe) lmem[la] <= lwd;
    lrd_q <= lmem[la];
  end

  // order table
  always_comb begin
    take = (qty_r < ord_q[O_QT +: 32]) ? qty_r : ord_q[O_QT +: 32];
    newq = ord_q[O_QT +: 32] - take;
    owe  = (cmd.clr && (32'(clr_r) < ORDER_SLOTS)) || cmd.add_wr || cmd.ord_upd;
    priority if (cmd.clr) begin
      oa_wr = OW'(clr_r);
      owd   = '0;
    end else if (cmd.add_wr) begin
      oa_wr = OW'(oid_r);
      owd   = {qty_r, ven_i, price_i, side_r, 1'b1};
    end else begin
      oa_wr = oaddr_r;
      owd   = ord_q;
      if (op_r == OP_EXECUTE) begin
        owd[0] = (newq != 32'd0);
        owd[O_QT +: 32] = newq;
      end else begin
        owd[0] = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (owe) omem[oa_wr] <= owd;
    ord_q <= omem[oa_rd];
  end

  // best price bookkeeping
  always_comb begin
    prev_cur = best_r[side_r];
    better   = (prev_cur == EMPTY) ||
               (side_r ? (PW'(price_i) > prev_cur) : (PW'(price_i) < prev_cur));
    srch_end = ss_r ? (sp_r == '0) : (sp_r == PIW'(PRICE_LEVELS - 1));
    mask     = row_mask(lrd_q);
  end

  always_comb begin
    st.op          = op_r;
    st.oid_ok      = 32'(oid_r) < ORDER_SLOTS;
    st.old_ok      = 32'(old_r) < ORDER_SLOTS;
    st.add_ok      = st.oid_ok && (32'(ven_r) < VENUE_COUNT) &&
                     (32'(price_r) < PRICE_LEVELS);
    st.clr_done    = (32'(clr_r) == CD - 1);
    st.rpt_need    = (prev_cur != EMPTY) && better;
    st.rec_valid   = ord_q[0];
    st.emptied_hit = (sum_new == 32'd0) && (best_r[rec_side_r] == PW'(rec_price_r));
    st.srch_stop   = lrd_q[0] || srch_end;
    st.line_last   = (lv_r == VW'(VENUE_COUNT - 1));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r     <= '0;
      best_r[0] <= EMPTY;
      best_r[1] <= EMPTY;
      out_valid <= 1'b0;
    end else begin
      if (cmd.clr && !st.clr_done) clr_r <= clr_r + 1'b1;
      if (cmd.add_wr && better) best_r[side_r] <= PW'(price_i);
      if (cmd.srch_chk) begin
        if (lrd_q[0])      best_r[ss_r] <= PW'(sp_r);
        else if (srch_end) best_r[ss_r] <= EMPTY;
      end
      out_valid <= cmd.rpt_out || cmd.line_emit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r    <= op_t'(in_opcode);
      oid_r   <= in_order_id;
      old_r   <= in_old_order_id;
      ven_r   <= in_venue;
      side_r  <= in_side;
      price_r <= in_price_ticks;
      qty_r   <= in_quantity;
    end
    if (cmd.add_wr) begin
      prev_r <= prev_cur;
      nsum_r <= sum_new;
    end
    if (cmd.oa_lat) oaddr_r <= oa_rd;
    if (cmd.ord_upd) begin
      rec_side_r  <= ord_q[1];
      rec_price_r <= ord_q[O_PR +: PIW];
      rec_ven_r   <= ord_q[O_VN +: VW];
      rq_r        <= (op_r == OP_EXECUTE) ? take : ord_q[O_QT +: 32];
    end
    if (cmd.srch_init) begin
      ss_r <= rec_side_r;
      sp_r <= rec_side_r ? PIW'(PRICE_LEVELS - 1) : '0;
    end else if (cmd.srch_chk && !lrd_q[0] && !srch_end) begin
      sp_r <= ss_r ? sp_r - 1'b1 : sp_r + 1'b1;
    end
    if (cmd.line_init) lv_r <= '0;
    else if (cmd.line_emit) lv_r <= lv_r + 1'b1;

    if (cmd.rpt_out) begin
      out_report_kind     <= KIND_BEST;
      out_price_out       <= price_r;
      out_level_total     <= nsum_r;
      out_old_price       <= 12'(prev_r);
      out_old_level_total <= lrd_q[32:1];
      out_venue_mask      <= mask[13:0];
      out_line_venue      <= 4'd0;
      out_line_venue_qty  <= 32'd0;
      out_last            <= 1'b1;
    end else if (cmd.line_emit) begin
      out_report_kind     <= KIND_LINE;
      out_price_out       <= 12'(rec_price_r);
      out_level_total     <= lrd_q[32:1];
      out_old_price       <= 12'd0;
      out_old_level_total <= 32'd0;
      out_venue_mask      <= mask[13:0];
      out_line_venue      <= 4'(lv_r);
      out_line_venue_qty  <= lrd_q[33 + 32 * lv_r +: 32];
      out_last            <= st.line_last;
    end
  end

  a_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(cmd.rpt_out || cmd.line_emit))
    else $error("result strobe without emit");
  a_bestw: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.add_wr |=> (best_r[$past(side_r)] != EMPTY))
    else $error("side empty after add");
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.add_wr && cmd.rem_wr))
    else $error("two level writers");

endmodule
`default_nettype wire

// ----- rtl/multi_venue_order_book_core.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Channel   Handshake            Ports
// input     start & !busy        in_opcode .. in_quantity
// result    out_valid strobe     out_report_kind .. out_last
//
// Reset runs a clearing pass over the level memory and order table, busy high.
// Add and replace may emit a best-price report; an execute of a live order emits
// one line result per venue. Freeing the best level adds a scan, level by level,
// through the level memory's single port.
// Each result shows for one cycle; the receiver cannot stall.
module multi_venue_order_book_core #(
  parameter int ORDER_SLOTS  = 1024,
  parameter int PRICE_LEVELS = 4096,
  parameter int VENUE_COUNT  = 14
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  in_opcode,
  input  wire logic [9:0]  in_order_id,
  input  wire logic [9:0]  in_old_order_id,
  input  wire logic [3:0]  in_venue,
  input  wire logic        in_side,
  input  wire logic [11:0] in_price_ticks,
  input  wire logic [31:0] in_quantity,
  output logic             out_valid,
  output logic             out_report_kind,
  output logic [11:0]      out_price_out,
  output logic [31:0]      out_level_total,
  output logic [11:0]      out_old_price,
  output logic [31:0]      out_old_level_total,
  output logic [13:0]      out_venue_mask,
  output logic [3:0]       out_line_venue,
  output logic [31:0]      out_line_venue_qty,
  output logic             out_last
);
  import mvob_pkg::*;

  ctrl_cmd_t cmd;
  dp_stat_t  st;

  // sequencer: one item at a time
  mvob_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .st    (st),
    .cmd   (cmd)
  );

  // level rows (per-venue qty + total), order table, best registers
  mvob_dp #(
    .ORDER_SLOTS  (ORDER_SLOTS),
    .PRICE_LEVELS (PRICE_LEVELS),
    .VENUE_COUNT  (VENUE_COUNT)
  ) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .st                  (st),
    .in_opcode           (in_opcode),
    .in_order_id         (in_order_id),
    .in_old_order_id     (in_old_order_id),
    .in_venue            (in_venue),
    .in_side             (in_side),
    .in_price_ticks      (in_price_ticks),
    .in_quantity         (in_quantity),
    .out_valid           (out_valid),
    .out_report_kind     (out_report_kind),
    .out_price_out       (out_price_out),
    .out_level_total     (out_level_total),
    .out_old_price       (out_old_price),
    .out_old_level_total (out_old_level_total),
    .out_venue_mask      (out_venue_mask),
    .out_line_venue      (out_line_venue),
    .out_line_venue_qty  (out_line_venue_qty),
    .out_last            (out_last)
  );

endmodule
`default_nettype wire

// ----- tb/multi_venue_order_book_checker.sv -----
`timescale 1ns / 1ps
module multi_venue_order_book_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic        busy,
  input  logic [1:0]  in_opcode,
  input  logic [9:0]  in_order_id,
  input  logic [9:0]  in_old_order_id,
  input  logic [3:0]  in_venue,
  input  logic        in_side,
  input  logic [11:0] in_price_ticks,
  input  logic [31:0] in_quantity,
  input  logic        out_valid,
  input  logic        out_report_kind,
  input  logic [11:0] out_price_out,
  input  logic [31:0] out_level_total,
  input  logic [11:0] out_old_price,
  input  logic [31:0] out_old_level_total,
  input  logic [13:0] out_venue_mask,
  input  logic [3:0]  out_line_venue,
  input  logic [31:0] out_line_venue_qty,
  input  logic        out_last,
  output int          fail_count,
  output int          pending,
  output int          report_count
);
  import mvob_pkg::*;

  localparam int SLOTS  = 1024;
  localparam int LEVELS = 4096;
  localparam int VENUES = 14;
  localparam logic [12:0] NO_LEVEL = 13'(LEVELS);

  typedef struct packed {
    logic        kind;
    logic [11:0] price;
    logic [31:0] total;
    logic [11:0] old_price;
    logic [31:0] old_total;
    logic [13:0] mask;
    logic [3:0]  line_venue;
    logic [31:0] line_qty;
    logic        last;
  } report_t;

  typedef struct {
    logic        side;
    logic [11:0] price;
    logic [3:0]  venue;
    logic [31:0] qty;
  } order_t;

  report_t     expected_reports[$];
  logic        live[SLOTS];
  order_t      orders[SLOTS];
  logic [31:0] venue_qty[2*LEVELS][VENUES];
  logic [31:0] level_total[2*LEVELS];
  logic        occupied[2*LEVELS];
  logic [12:0] best[2];

  function automatic logic [31:0] add_sat(logic [31:0] a, logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? '1 : s[31:0];
  endfunction

  function automatic logic [31:0] sub_sat(logic [31:0] a, logic [31:0] b);
    return (b > a) ? '0 : a - b;
  endfunction

  function automatic int lvl(logic s, logic [11:0] p);
    return int'(s) * LEVELS + int'(p);
  endfunction

  function automatic logic [13:0] mask_of(int lv);
    logic [13:0] m;
    m = '0;
    for (int v = 0; v < VENUES; v++) if (venue_qty[lv][v] != 0) m[v] = 1'b1;
    return m;
  endfunction

  function automatic logic [12:0] scan_best(logic s);
    if (s) begin
      for (int p = LEVELS - 1; p >= 0; p--) if (occupied[LEVELS + p]) return 13'(p);
    end else begin
      for (int p = 0; p < LEVELS; p++) if (occupied[p]) return 13'(p);
    end
    return NO_LEVEL;
  endfunction

  task automatic take_out(logic s, logic [11:0] p, logic [3:0] v, logic [31:0] q);
    int lv;
    lv = lvl(s, p);
    venue_qty[lv][v] = sub_sat(venue_qty[lv][v], q);
    level_total[lv] = sub_sat(level_total[lv], q);
    if (level_total[lv] == 0) begin
      for (int i = 0; i < VENUES; i++) venue_qty[lv][i] = '0;
      occupied[lv] = 1'b0;
      if (best[s] == {1'b0, p}) best[s] = scan_best(s);
    end
  endtask

  task automatic cancel_order(logic [9:0] id);
    if (!live[id]) return;
    live[id] = 1'b0;
    take_out(orders[id].side, orders[id].price, orders[id].venue, orders[id].qty);
  endtask

  task automatic add_order(logic [9:0] id, logic [3:0] v, logic s, logic [11:0] p,
                           logic [31:0] q);
    logic [12:0] prev;
    int lv;
    report_t r;
    if (v >= VENUES) return;
    prev = best[s];
    lv = lvl(s, p);
    venue_qty[lv][v] = add_sat(venue_qty[lv][v], q);
    level_total[lv] = add_sat(level_total[lv], q);
    occupied[lv] = 1'b1;
    if (prev == NO_LEVEL || (s ? {1'b0, p} > prev : {1'b0, p} < prev)) best[s] = {1'b0, p};
    orders[id] = '{s, p, v, q};
    live[id] = 1'b1;
    if (prev == NO_LEVEL || best[s] == prev) return;
    r = '0;
    r.kind = KIND_BEST;
    r.price = best[s][11:0];
    r.total = level_total[lvl(s, best[s][11:0])];
    r.old_price = prev[11:0];
    r.old_total = level_total[lvl(s, prev[11:0])];
    r.mask = mask_of(lvl(s, prev[11:0]));
    r.last = 1'b1;
    expected_reports = {expected_reports, r};
  endtask

  task automatic execute_order(logic [9:0] id, logic [31:0] q);
    logic [31:0] fill;
    int lv;
    report_t r;
    if (!live[id]) return;
    fill = (q < orders[id].qty) ? q : orders[id].qty;
    orders[id].qty -= fill;
    take_out(orders[id].side, orders[id].price, orders[id].venue, fill);
    lv = lvl(orders[id].side, orders[id].price);
    for (int v = 0; v < VENUES; v++) begin
      r = '0;
      r.kind = KIND_LINE;
      r.price = orders[id].price;
      r.total = level_total[lv];
      r.mask = mask_of(lv);
      r.line_venue = 4'(v);
      r.line_qty = venue_qty[lv][v];
      r.last = (v == VENUES - 1);
      expected_reports = {expected_reports, r};
    end
    if (orders[id].qty == 0) live[id] = 1'b0;
  endtask

  report_t got;
  report_t want;

  initial begin
    fail_count = 0;
    report_count = 0;
    pending = 0;
    for (int i = 0; i < SLOTS; i++) live[i] = 1'b0;
    for (int i = 0; i < 2*LEVELS; i++) begin
      level_total[i] = '0;
      occupied[i] = 1'b0;
      for (int v = 0; v < VENUES; v++) venue_qty[i][v] = '0;
    end
    best[0] = NO_LEVEL;
    best[1] = NO_LEVEL;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      // results first: an item accepted this edge cannot have produced them yet
      if (out_valid) begin
        got = '{out_report_kind, out_price_out, out_level_total, out_old_price,
                out_old_level_total, out_venue_mask, out_line_venue,
                out_line_venue_qty, out_last};
        report_count++;
        if (expected_reports.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("unexpected result %p", got);
        end else begin
          want = expected_reports.pop_front();
          if (got !== want) begin
            fail_count++;
            if (fail_count <= 10) $display("mismatch: expected %p actual %p", want, got);
          end
        end
      end
      if (start && !busy) begin
        case (op_t'(in_opcode))
          OP_ADD: add_order(in_order_id, in_venue, in_side, in_price_ticks, in_quantity);
          OP_CANCEL: cancel_order(in_order_id);
          OP_REPLACE: begin
            add_order(in_order_id, in_venue, in_side, in_price_ticks, in_quantity);
            cancel_order(in_old_order_id);
          end
          default: execute_order(in_order_id, in_quantity);
        endcase
      end
      pending = expected_reports.size();
    end
  end
endmodule

// ----- tb/multi_venue_order_book_core_test.sv -----
`timescale 1ns / 1ps
module multi_venue_order_book_core_test;
  import mvob_pkg::*;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [1:0]  in_opcode;
  logic [9:0]  in_order_id;
  logic [9:0]  in_old_order_id;
  logic [3:0]  in_venue;
  logic        in_side;
  logic [11:0] in_price_ticks;
  logic [31:0] in_quantity;
  logic        out_valid;
  logic        out_report_kind;
  logic [11:0] out_price_out;
  logic [31:0] out_level_total;
  logic [11:0] out_old_price;
  logic [31:0] out_old_level_total;
  logic [13:0] out_venue_mask;
  logic [3:0]  out_line_venue;
  logic [31:0] out_line_venue_qty;
  logic        out_last;
  int          fail_count;
  int          pending;
  int          report_count;

  // Idle limit: above both the reset clear pass and a worst-case best-level scan;
  // between accepts nothing correct waits longer than this.
  localparam int IDLE_LIMIT = 60000;

  // Venue choice for random adds: mostly legal, now and then 14 or 15.
  localparam int VENUE_PICK = 15;

  int idle_cycles;
  int items_sent;
  int op_counts[4];
  bit quiet;        // no random idling during this stretch

  multi_venue_order_book_core DUT (.*);

  multi_venue_order_book_checker book_check (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog: counts cycles in which no item and no result is accepted.
  always @(posedge clk) begin
    if ((start && !busy) || out_valid || !rst_n) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog expired after %0d idle cycles", idle_cycles);
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Drive one item and hold start until the block takes it. Random gaps
  // before start rise give ~30% idling except in the quiet stretch.
  task automatic send(op_t op, logic [9:0] id, logic [9:0] old_id, logic [3:0] ven,
                      logic s, logic [11:0] price, logic [31:0] qty);
    @(posedge clk);
    while (!quiet && $urandom_range(99) < 30) @(posedge clk);
    start <= 1'b1;
    in_opcode <= op;
    in_order_id <= id;
    in_old_order_id <= old_id;
    in_venue <= ven;
    in_side <= s;
    in_price_ticks <= price;
    in_quantity <= qty;
    @(posedge clk);
    while (busy) @(posedge clk);
    start <= 1'b0;
    items_sent++;
    op_counts[op]++;
  endtask

  // Wait until every expected result has come; replaces and cancels may still be
  // finishing a level scan afterward, and busy covers that before the next item.
  task automatic drain();
    @(negedge clk);
    while (pending != 0) @(negedge clk);
  endtask

  function automatic logic [31:0] rand_qty();
    case ($urandom_range(5))
      0: return $urandom();
      1: return 32'hFFFF_FFFF - $urandom_range(50);
      2: return 0;
      default: return $urandom_range(1, 1000);
    endcase
  endfunction

  // Recently used ids so that cancels, replaces and executes hit live orders.
  logic [9:0] recent[$];

  function automatic logic [9:0] pick_id();
    if (recent.size() != 0 && $urandom_range(99) < 80)
      return recent[$urandom_range(recent.size() - 1)];
    return 10'($urandom());
  endfunction

  initial begin
    logic [9:0]  id;
    logic [9:0]  id2;
    logic [11:0] base;
    logic        s;
    int          r;
    rst_n = 1'b0;
    start = 1'b0;
    in_opcode = OP_ADD;
    in_order_id = '0;
    in_old_order_id = '0;
    in_venue = '0;
    in_side = 1'b0;
    in_price_ticks = '0;
    in_quantity = '0;
    items_sent = 0;
    quiet = 1'b0;
    foreach (op_counts[i]) op_counts[i] = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty-side first add, best moves, saturating totals, extremes.
    send(OP_ADD, 10'd0, 10'd0, 4'd0, 1'b0, 12'd100, 32'd5);            // first ask, silent
    send(OP_ADD, 10'd1, 10'd0, 4'd13, 1'b0, 12'd50, 32'd7);            // ask best moves down
    send(OP_ADD, 10'd2, 10'd0, 4'd3, 1'b0, 12'd200, 32'd1);            // worse ask, silent
    send(OP_ADD, 10'd3, 10'd0, 4'd5, 1'b1, 12'd4095, 32'hFFFF_FFFF);   // first bid at top
    send(OP_ADD, 10'd4, 10'd0, 4'd6, 1'b1, 12'd4095, 32'd9);           // total saturates
    send(OP_ADD, 10'd5, 10'd0, 4'd1, 1'b1, 12'd0, 32'd0);              // zero-qty level
    send(OP_ADD, 10'd6, 10'd0, 4'd14, 1'b0, 12'd10, 32'd3);            // bad venue, ignored
    send(OP_ADD, 10'd7, 10'd0, 4'd15, 1'b1, 12'd10, 32'd3);            // bad venue, ignored
    send(OP_ADD, 10'd8, 10'd0, 4'd2, 1'b0, 12'd0, 32'd4);              // ask best to price 0
    send(OP_CANCEL, 10'd999, 10'd0, 4'd0, 1'b0, 12'd0, 32'd0);         // unknown id
    send(OP_EXECUTE, 10'd1023, 10'd0, 4'd0, 1'b0, 12'd0, 32'd1);       // unknown id
    send(OP_EXECUTE, 10'd1, 10'd0, 4'd0, 1'b0, 12'd0, 32'd3);          // partial fill
    send(OP_EXECUTE, 10'd8, 10'd0, 4'd0, 1'b0, 12'd0, 32'hFFFF_FFFF);  // capped, level emptied
    send(OP_CANCEL, 10'd1, 10'd0, 4'd0, 1'b0, 12'd0, 32'd0);           // best freed, rescan
    send(OP_REPLACE, 10'd9, 10'd0, 4'd7, 1'b0, 12'd20, 32'd11);        // replace moves best
    send(OP_REPLACE, 10'd10, 10'd10, 4'd8, 1'b1, 12'd300, 32'd2);      // replace cancels itself
    send(OP_ADD, 10'd3, 10'd0, 4'd9, 1'b0, 12'd4094, 32'd1);           // overwrite live id
    send(OP_EXECUTE, 10'd4, 10'd0, 4'd0, 1'b1, 12'd0, 32'd0);          // zero fill
    send(OP_EXECUTE, 10'd5, 10'd0, 4'd0, 1'b1, 12'd0, 32'd1);          // zero-qty order
    send(OP_CANCEL, 10'd4, 10'd0, 4'd0, 1'b1, 12'd0, 32'd0);           // saturated level
    send(OP_REPLACE, 10'd11, 10'd1023, 4'd13, 1'b1, 12'd4095, 32'd1);  // max fields
    drain();

    // Hold off until the book is quiet, then run the clustered random part.
    for (int k = 0; k < 150; k++) begin
      quiet = (k >= 60 && k < 100);
      if (k == 110) drain();
      s = $urandom_range(1);
      base = s ? 12'(2000 + $urandom_range(12)) : 12'(1990 + $urandom_range(12));
      if ($urandom_range(19) == 0) base = 12'($urandom());
      r = $urandom_range(99);
      id = pick_id();
      id2 = pick_id();
      if (r < 40) begin
        if ($urandom_range(1)) id = 10'($urandom());
        send(OP_ADD, id, 10'($urandom()), 4'($urandom_range(VENUE_PICK)), s, base,
             rand_qty());
        recent = {recent, id};
        if (recent.size() > 24) void'(recent.pop_front());
      end else if (r < 55) begin
        send(OP_CANCEL, id, 10'($urandom()), 4'($urandom()), s, 12'($urandom()),
             $urandom());
      end else if (r < 70) begin
        send(OP_REPLACE, 10'($urandom()), id2, 4'($urandom_range(VENUE_PICK)), s, base,
             rand_qty());
      end else begin
        send(OP_EXECUTE, id, 10'($urandom()), 4'($urandom()), s, 12'($urandom()),
             rand_qty());
      end
    end
    quiet = 1'b0;
    drain();
    repeat (40) @(posedge clk);

    $display("sent %0d items (add %0d cancel %0d replace %0d execute %0d)", items_sent,
             op_counts[0], op_counts[1], op_counts[2], op_counts[3]);
    $display("checked %0d results against the book predictor", report_count);
    if (fail_count == 0 && pending == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule

// ----- filelist.f -----
rtl/mvob_pkg.sv
rtl/mvob_ctrl.sv
rtl/mvob_dp.sv
rtl/multi_venue_order_book_core.sv
tb/multi_venue_order_book_checker.sv
tb/multi_venue_order_book_core_test.sv
